// ----- src/rm2aa_pkg.sv -----
package rm2aa_pkg;

	// Internal fixed point: quaternion parts at 24 fraction bits fit in 28 signed bits.
	localparam int INT_FRAC     = 24;
	localparam int QW           = 28;
	localparam int SQ_W         = 2 * QW;
	localparam int REM_W        = SQ_W + 2;
	localparam int CORDIC_STEPS = 24;
	localparam int XW           = 32;
	localparam int AW           = 27;
	localparam int DIV_W        = 64;

	// Rotation angle of CORDIC step i in units of 2^-24 rad.
	function automatic logic signed [AW-1:0] atan_step(input int i);
		logic signed [AW-1:0] r;
		case (i)
			0: r = 27'sd13176795;
			1: r = 27'sd7778716;
			2: r = 27'sd4110060;
			3: r = 27'sd2086331;
			4: r = 27'sd1047214;
			5: r = 27'sd524117;
			6: r = 27'sd262123;
			7: r = 27'sd131069;
			default: r = AW'(1) << (INT_FRAC - i);
		endcase
		return r;
	endfunction

endpackage

// ----- src/rm2aa_sqrt_cell.sv -----
module rm2aa_sqrt_cell #(
	parameter int K  = 0,
	parameter int TW = 1
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_in,
	input  logic [rm2aa_pkg::REM_W-1:0]     rem_in,
	input  logic [rm2aa_pkg::QW-1:0]        root_in,
	input  logic [TW-1:0]                   tag_in,
	output logic                            vld_out,
	output logic [rm2aa_pkg::REM_W-1:0]     rem_out,
	output logic [rm2aa_pkg::QW-1:0]        root_out,
	output logic [TW-1:0]                   tag_out
);
	import rm2aa_pkg::*;

	logic [REM_W-1:0] trial;
	logic             take;

	// Root bits below K are still zero, so (2r + 2^K) * 2^K is the increase of the square.
	assign trial = (REM_W'(root_in) << (K + 1)) + (REM_W'(1) << (2 * K));
	assign take  = rem_in >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? rem_in - trial : rem_in;
			root_out <= take ? (root_in | (QW'(1) << K)) : root_in;
			tag_out  <= tag_in;
		end
	end

endmodule

// ----- src/rm2aa_cordic_cell.sv -----
module rm2aa_cordic_cell #(
	parameter int I  = 0,
	parameter int TW = 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               vld_in,
	input  logic signed [rm2aa_pkg::XW-1:0]    x_in,
	input  logic signed [rm2aa_pkg::XW-1:0]    y_in,
	input  logic signed [rm2aa_pkg::AW-1:0]    a_in,
	input  logic [TW-1:0]                      tag_in,
	output logic                               vld_out,
	output logic signed [rm2aa_pkg::XW-1:0]    x_out,
	output logic signed [rm2aa_pkg::XW-1:0]    y_out,
	output logic signed [rm2aa_pkg::AW-1:0]    a_out,
	output logic [TW-1:0]                      tag_out
);
	import rm2aa_pkg::*;

	localparam logic signed [AW-1:0] STEP = atan_step(I);

	logic signed [XW-1:0] dx, dy;

	assign dx = y_in >>> I;
	assign dy = x_in >>> I;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[XW-1]) begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				a_out <= a_in + STEP;
			end else begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				a_out <= a_in - STEP;
			end
			tag_out <= tag_in;
		end
	end

endmodule

// ----- src/rm2aa_div_cell.sv -----
module rm2aa_div_cell #(
	parameter int K   = 0,
	parameter int QBW = 16,
	parameter int TW  = 1
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vld_in,
	input  logic [rm2aa_pkg::DIV_W-1:0]         den_in,
	input  logic [2:0][rm2aa_pkg::DIV_W-1:0]    rem_in,
	input  logic [2:0][QBW-1:0]                 quo_in,
	input  logic [TW-1:0]                       tag_in,
	output logic                                vld_out,
	output logic [rm2aa_pkg::DIV_W-1:0]         den_out,
	output logic [2:0][rm2aa_pkg::DIV_W-1:0]    rem_out,
	output logic [2:0][QBW-1:0]                 quo_out,
	output logic [TW-1:0]                       tag_out
);
	import rm2aa_pkg::*;

	logic [DIV_W-1:0] cmp;

	assign cmp = den_in << K;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				if (rem_in[j] >= cmp) begin
					rem_out[j] <= rem_in[j] - cmp;
					quo_out[j] <= quo_in[j] | (QBW'(1) << K);
				end else begin
					rem_out[j] <= rem_in[j];
					quo_out[j] <= quo_in[j];
				end
			end
			den_out <= den_in;
			tag_out <= tag_in;
		end
	end

endmodule

// ----- src/rotation_matrix_to_axis_angle.sv -----
// Channel   Direction  Word
// s_axis    in         tdata: m00 m01 m02 m10 m11 m12 m20 m21 m22, DATA_WIDTH bits each
// m_axis    out        tdata: axis_x axis_y axis_z, DATA_WIDTH bits each
// cfg       in         cfg_data: eps_threshold, written when cfg_we is high
//
// One word is accepted per cycle while s_tready is high; each word passes through the
// 28-cell square-root row, the 24-cell CORDIC row and the divider row.
// arst_n clears every valid bit and eps_threshold; no clearing pass is needed.
// A stalled output word sits in the output register while a skid register takes one more;
// only when the skid register is full does the whole cell row hold and s_tready fall.
module rotation_matrix_to_axis_angle #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [DATA_WIDTH-1:0]                         cfg_data,
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, zero padded
	input  logic [((9 * DATA_WIDTH + 7) / 8) * 8 - 1:0]   s_tdata,
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	// axis_x, axis_y, axis_z from bit 0 up, zero padded
	output logic [((3 * DATA_WIDTH + 7) / 8) * 8 - 1:0]   m_tdata
);
	import rm2aa_pkg::*;

	localparam int DW    = DATA_WIDTH;
	localparam int OUT_W = ((3 * DW + 7) / 8) * 8;
	localparam int TW    = DW + 3;
	localparam int UP    = (DW - 2 <= INT_FRAC) ? INT_FRAC - (DW - 2) : 0;
	localparam int DN    = (DW - 2 > INT_FRAC) ? (DW - 2) - INT_FRAC : 0;
	localparam int SHM   = (DW > 27) ? DW - 27 : 0;
	localparam int SHD   = (DW < 27) ? 27 - DW : 0;
	localparam int SQ_TW = 1 + 4 * QW;
	localparam int CO_TW = 2 + 4 * QW;
	localparam int DV_TW = 7;

	function automatic logic signed [QW-1:0] to_int(input logic signed [TW-1:0] v);
		logic signed [63:0] e;
		e = 64'(v);
		e = e <<< UP;
		e = e >>> DN;
		return e[QW-1:0];
	endfunction

	logic                 en;
	logic signed [DW-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= '0;
		end else if (cfg_we) begin
			eps_q <= cfg_data;
		end
	end

	// Case selection on the transposed matrix.
	logic signed [DW-1:0] m [9];
	logic signed [TW-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22, one;
	logic signed [TW-1:0] t, qw, qx, qy, qz;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = s_tdata[i * DW +: DW];
		end
	end

	assign r00 = TW'(m[0]);
	assign r10 = TW'(m[1]);
	assign r20 = TW'(m[2]);
	assign r01 = TW'(m[3]);
	assign r11 = TW'(m[4]);
	assign r21 = TW'(m[5]);
	assign r02 = TW'(m[6]);
	assign r12 = TW'(m[7]);
	assign r22 = TW'(m[8]);
	assign one = TW'(1) << (DW - 2);

	always_comb begin
		if (m[8] < eps_q) begin
			if (r00 > r11) begin
				t  = one + r00 - r11 - r22;
				qw = r12 - r21;
				qx = t;
				qy = r01 + r10;
				qz = r20 + r02;
			end else begin
				t  = one - r00 + r11 - r22;
				qw = r20 - r02;
				qx = r01 + r10;
				qy = t;
				qz = r12 + r21;
			end
		end else begin
			if (r00 < -r11) begin
				t  = one - r00 - r11 + r22;
				qw = r01 - r10;
				qx = r20 + r02;
				qy = r12 + r21;
				qz = t;
			end else begin
				t  = one + r00 + r11 + r22;
				qw = t;
				qx = r12 - r21;
				qy = r20 - r02;
				qz = r01 - r10;
			end
		end
	end

	logic                 vld_s1, vld_s2, vld_s3;
	logic                 zero_s1, zero_s2, zero_s3;
	logic signed [QW-1:0] w_s1, w_s2, w_s3;
	logic signed [QW-1:0] p_s1 [3];
	logic signed [QW-1:0] p_s2 [3];
	logic signed [QW-1:0] p_s3 [3];
	logic [SQ_W-1:0]      sq_s2 [3];
	logic [SQ_W-1:0]      sum_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s1 <= t <= 0;
			w_s1    <= to_int(qw);
			p_s1[0] <= to_int(qx);
			p_s1[1] <= to_int(qy);
			p_s1[2] <= to_int(qz);
			zero_s2 <= zero_s1;
			w_s2    <= w_s1;
			for (int j = 0; j < 3; j++) begin
				p_s2[j]  <= p_s1[j];
				sq_s2[j] <= SQ_W'(p_s1[j] * p_s1[j]);
				p_s3[j]  <= p_s2[j];
			end
			sum_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			zero_s3 <= zero_s2 || ((sq_s2[0] | sq_s2[1] | sq_s2[2]) == '0);
			w_s3    <= w_s2;
		end
	end

	// Square root, one result bit per cell.
	logic                 sq_vld  [QW+1];
	logic [REM_W-1:0]     sq_rem  [QW+1];
	logic [QW-1:0]        sq_root [QW+1];
	logic [SQ_TW-1:0]     sq_tag  [QW+1];

	assign sq_vld[0]  = vld_s3;
	assign sq_rem[0]  = REM_W'(sum_s3);
	assign sq_root[0] = '0;
	assign sq_tag[0]  = {zero_s3, w_s3, p_s3[2], p_s3[1], p_s3[0]};

	for (genvar g = 0; g < QW; g++) begin : g_sqrt
		rm2aa_sqrt_cell #(.K(QW - 1 - g), .TW(SQ_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(sq_vld[g]), .rem_in(sq_rem[g]), .root_in(sq_root[g]), .tag_in(sq_tag[g]),
			.vld_out(sq_vld[g+1]), .rem_out(sq_rem[g+1]), .root_out(sq_root[g+1]),
			.tag_out(sq_tag[g+1])
		);
	end

	// CORDIC vectoring on (|w|, s).
	logic signed [QW-1:0] w_sq;
	logic [QW-1:0]        w_abs;

	assign w_sq  = sq_tag[QW][4*QW-1:3*QW];
	assign w_abs = w_sq[QW-1] ? QW'(-w_sq) : QW'(w_sq);

	logic                 co_vld [CORDIC_STEPS+1];
	logic signed [XW-1:0] co_x   [CORDIC_STEPS+1];
	logic signed [XW-1:0] co_y   [CORDIC_STEPS+1];
	logic signed [AW-1:0] co_a   [CORDIC_STEPS+1];
	logic [CO_TW-1:0]     co_tag [CORDIC_STEPS+1];

	assign co_vld[0] = sq_vld[QW];
	assign co_x[0]   = XW'(w_abs);
	assign co_y[0]   = XW'(sq_root[QW]);
	assign co_a[0]   = '0;
	assign co_tag[0] = {sq_tag[QW][SQ_TW-1], w_sq[QW-1], sq_tag[QW][3*QW-1:0], sq_root[QW]};

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		rm2aa_cordic_cell #(.I(g), .TW(CO_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(co_vld[g]), .x_in(co_x[g]), .y_in(co_y[g]), .a_in(co_a[g]),
			.tag_in(co_tag[g]),
			.vld_out(co_vld[g+1]), .x_out(co_x[g+1]), .y_out(co_y[g+1]), .a_out(co_a[g+1]),
			.tag_out(co_tag[g+1])
		);
	end

	// Scale stages: theta, products, dividend and divisor, range check.
	logic [CO_TW-1:0]           ct;
	logic signed [AW:0]         theta2;
	logic                       vld_s4, vld_s5, vld_s6, vld_s7;
	logic                       zero_s4, zero_s5, zero_s6, zero_s7;
	logic signed [AW:0]         theta_s4;
	logic signed [QW-1:0]       p_s4 [3];
	logic [QW-1:0]              s_s4, s_s5;
	logic signed [2*QW-1:0]     num_s5 [3];
	logic [2:0]                 neg_s6, neg_s7, ovf_s7;
	logic [2:0][DIV_W-1:0]      n_s6, n_s7;
	logic [DIV_W-1:0]           d_s6, d_s7;
	logic [2:0][DIV_W-1:0]      mag;

	assign ct     = co_tag[CORDIC_STEPS];
	assign theta2 = (AW + 1)'(co_a[CORDIC_STEPS]) <<< 1;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			mag[j] = num_s5[j][2*QW-1] ? DIV_W'(-num_s5[j]) : DIV_W'(num_s5[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s4 <= co_vld[CORDIC_STEPS];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s4  <= ct[CO_TW-1];
			theta_s4 <= ct[CO_TW-2] ? -theta2 : theta2;
			for (int j = 0; j < 3; j++) begin
				p_s4[j] <= ct[QW*(j+1) +: QW];
			end
			s_s4 <= ct[QW-1:0];

			zero_s5 <= zero_s4;
			s_s5    <= s_s4;
			for (int j = 0; j < 3; j++) begin
				num_s5[j] <= (2*QW)'(theta_s4) * (2*QW)'(p_s4[j]);
			end

			zero_s6 <= zero_s5;
			d_s6    <= (DIV_W'(s_s5) << SHD) << 1;
			for (int j = 0; j < 3; j++) begin
				neg_s6[j] <= num_s5[j][2*QW-1];
				n_s6[j]   <= ((mag[j] << SHM) << 1) + (DIV_W'(s_s5) << SHD);
			end

			zero_s7 <= zero_s6;
			neg_s7  <= neg_s6;
			d_s7    <= d_s6;
			n_s7    <= n_s6;
			for (int j = 0; j < 3; j++) begin
				ovf_s7[j] <= n_s6[j] >= (d_s6 << DW);
			end
		end
	end

	// Restoring division, one quotient bit per cell.
	logic                  dv_vld [DW+1];
	logic [DIV_W-1:0]      dv_den [DW+1];
	logic [2:0][DIV_W-1:0] dv_rem [DW+1];
	logic [2:0][DW-1:0]    dv_quo [DW+1];
	logic [DV_TW-1:0]      dv_tag [DW+1];

	assign dv_vld[0] = vld_s7;
	assign dv_den[0] = d_s7;
	assign dv_rem[0] = n_s7;
	assign dv_quo[0] = '0;
	assign dv_tag[0] = {zero_s7, ovf_s7, neg_s7};

	for (genvar g = 0; g < DW; g++) begin : g_div
		rm2aa_div_cell #(.K(DW - 1 - g), .QBW(DW), .TW(DV_TW)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en),
			.vld_in(dv_vld[g]), .den_in(dv_den[g]), .rem_in(dv_rem[g]), .quo_in(dv_quo[g]),
			.tag_in(dv_tag[g]),
			.vld_out(dv_vld[g+1]), .den_out(dv_den[g+1]), .rem_out(dv_rem[g+1]),
			.quo_out(dv_quo[g+1]), .tag_out(dv_tag[g+1])
		);
	end

	// Saturation and packing.
	logic [OUT_W-1:0] fin_data;
	logic [DV_TW-1:0] ft;
	logic [DW:0]      qe, mg, lim;

	assign ft  = dv_tag[DW];
	assign lim = (DW + 1)'(1) << (DW - 1);

	always_comb begin
		fin_data = '0;
		qe       = '0;
		mg       = '0;
		for (int j = 0; j < 3; j++) begin
			qe = {1'b0, dv_quo[DW][j]};
			if (ft[j]) begin
				mg = (ft[3 + j] || qe > lim) ? lim : qe;
				mg = -mg;
			end else begin
				mg = (ft[3 + j] || qe > lim - 1'b1) ? lim - 1'b1 : qe;
			end
			fin_data[j * DW +: DW] = ft[6] ? '0 : mg[DW-1:0];
		end
	end

	// Output register with a skid register behind it.
	logic             out_vld_q, skid_vld_q;
	logic [OUT_W-1:0] out_data_q, skid_data_q;
	logic             fin_vld;

	assign fin_vld  = dv_vld[DW];
	assign en       = !skid_vld_q;
	assign s_tready = en;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= fin_vld;
			end
		end else if (fin_vld && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_data_q <= skid_vld_q ? skid_data_q : fin_data;
		end else if (fin_vld && en) begin
			skid_data_q <= fin_data;
		end
	end

endmodule

// ----- tb/rotation_matrix_to_axis_angle_checker.sv -----
`timescale 1ns / 100ps

module rotation_matrix_to_axis_angle_checker #(
	parameter int DATA_WIDTH = 16
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_we,
	input  logic [DATA_WIDTH-1:0]                         cfg_data,
	input  logic                                          s_tvalid,
	input  logic                                          s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up
	input  logic [((9 * DATA_WIDTH + 7) / 8) * 8 - 1:0]   s_tdata,
	input  logic                                          m_tvalid,
	input  logic                                          m_tready,
	// axis_x, axis_y, axis_z from bit 0 up
	input  logic [((3 * DATA_WIDTH + 7) / 8) * 8 - 1:0]   m_tdata,
	output int                                            fail_count,
	output int                                            pending
);

	localparam int IN_FRAC  = DATA_WIDTH - 2;
	localparam int OUT_FRAC = DATA_WIDTH - 3;
	localparam int IFRAC    = 24;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] z;
		logic [DATA_WIDTH-1:0] y;
		logic [DATA_WIDTH-1:0] x;
	} axis_vec_t;

	axis_vec_t   vec_fifo[$];
	longint      eps_q;

	function automatic longint fshift(longint v, int n);
		return v >>> n;
	endfunction

	function automatic longint to_fine(longint v);
		if (IFRAC >= IN_FRAC)
			return v * (longint'(1) << (IFRAC - IN_FRAC));
		return v >>> (IN_FRAC - IFRAC);
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	function automatic longint half_angle(longint x, longint y);
		longint a, dx, dy, st;
		longint tbl[8];
		a = 0;
		tbl = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
		for (int i = 0; i < 24; i++) begin
			dx = fshift(y, i);
			dy = fshift(x, i);
			st = (i < 8) ? tbl[i] : (longint'(1) << (IFRAC - i));
			if (y >= 0) begin
				x += dx; y -= dy; a += st;
			end else begin
				x -= dx; y += dy; a -= st;
			end
		end
		return a;
	endfunction

	function automatic logic [DATA_WIDTH-1:0] scale_sat(longint th, longint c, longint s);
		longint num;
		longint unsigned mag, d, q, lim;
		bit neg;
		num = th * c;
		neg = num < 0;
		mag = neg ? -num : num;
		d = s;
		if (OUT_FRAC >= IFRAC) mag <<= (OUT_FRAC - IFRAC);
		else d <<= (IFRAC - OUT_FRAC);
		q = (2 * mag + d) / (2 * d);
		if (neg) begin
			lim = 64'd1 << (DATA_WIDTH - 1);
			if (q > lim) q = lim;
			return DATA_WIDTH'(-longint'(q));
		end
		lim = (64'd1 << (DATA_WIDTH - 1)) - 1;
		if (q > lim) q = lim;
		return DATA_WIDTH'(q);
	endfunction

	function automatic axis_vec_t matrix_to_axis(logic [9*DATA_WIDTH-1:0] w);
		longint m[9], q[4], t, one, s, th, wf;
		longint p[3];
		longint unsigned s2;
		axis_vec_t r;
		one = longint'(1) << IN_FRAC;
		for (int i = 0; i < 9; i++)
			m[i] = longint'($signed(w[i*DATA_WIDTH +: DATA_WIDTH]));
		// The transposed entry R[i][j] is m[j*3+i].
		if (m[8] < eps_q) begin
			if (m[0] > m[4]) begin
				t = one + m[0] - m[4] - m[8];
				q = '{m[7] - m[5], t, m[3] + m[1], m[2] + m[6]};
			end else begin
				t = one - m[0] + m[4] - m[8];
				q = '{m[2] - m[6], m[3] + m[1], t, m[5] + m[7]};
			end
		end else begin
			if (m[0] < -m[4]) begin
				t = one - m[0] - m[4] + m[8];
				q = '{m[3] - m[1], m[2] + m[6], m[5] + m[7], t};
			end else begin
				t = one + m[0] + m[4] + m[8];
				q = '{t, m[7] - m[5], m[2] - m[6], m[3] - m[1]};
			end
		end
		r = '0;
		if (t > 0) begin
			wf = to_fine(q[0]);
			s2 = 0;
			for (int i = 0; i < 3; i++) begin
				p[i] = to_fine(q[i+1]);
				s2 += longint'(p[i] * p[i]);
			end
			if (s2 != 0) begin
				s = int_sqrt(s2);
				th = 2 * half_angle(wf < 0 ? -wf : wf, s);
				if (wf < 0) th = -th;
				r.x = scale_sat(th, p[0], s);
				r.y = scale_sat(th, p[1], s);
				r.z = scale_sat(th, p[2], s);
			end
		end
		return r;
	endfunction

	assign pending = vec_fifo.size();

	always @(posedge clk or negedge arst_n) begin
		axis_vec_t want, got;
		if (!arst_n) begin
			eps_q <= 0;
			fail_count <= 0;
			vec_fifo.delete();
		end else begin
			if (cfg_we)
				eps_q <= longint'($signed(cfg_data));
			if (s_tvalid && s_tready)
				vec_fifo.push_back(matrix_to_axis(s_tdata[9*DATA_WIDTH-1:0]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[3*DATA_WIDTH-1:0];
				if (vec_fifo.size() == 0) begin
					$error("Unexpected output word %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = vec_fifo.pop_front();
					if (want != got) begin
						fail_count <= fail_count + 1;
						if (want.x != got.x)
							$error("axis_x expected %0d got %0d", $signed(want.x), $signed(got.x));
						if (want.y != got.y)
							$error("axis_y expected %0d got %0d", $signed(want.y), $signed(got.y));
						if (want.z != got.z)
							$error("axis_z expected %0d got %0d", $signed(want.z), $signed(got.z));
					end
				end
			end
		end
	end

endmodule

// ----- tb/rotation_matrix_to_axis_angle_tb.sv -----
`timescale 1ns / 100ps

module rotation_matrix_to_axis_angle_tb;

	localparam int DW      = 16;
	localparam int IN_W    = ((9 * DW + 7) / 8) * 8;
	localparam int OUT_W   = ((3 * DW + 7) / 8) * 8;
	localparam int ONE     = 1 << (DW - 2);
	localparam int LATENCY = 60 + DW;
	localparam int WATCHDOG = 20000;

	logic             clk = 0;
	logic             arst_n = 0;
	logic             cfg_we = 0;
	logic [DW-1:0]    cfg_data = '0;
	logic             s_tvalid = 0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	int               fail_count, pending;
	int               idle_cycles;
	int               rx_wait;
	bit               hold_off = 0;
	bit               stim_done = 0;

	always #10 clk = ~clk;

	rotation_matrix_to_axis_angle #(.DATA_WIDTH(DW)) u_dut (.*);

	rotation_matrix_to_axis_angle_checker #(.DATA_WIDTH(DW)) u_checker (.*);

	// Receiver: after each word it waits a drawn number of cycles, with a long hold-off
	// when asked.
	always @(posedge clk) begin
		int gap;
		if (!arst_n) begin
			m_tready <= 0;
			rx_wait <= 0;
		end else if (hold_off) begin
			m_tready <= 0;
		end else if (m_tready && m_tvalid) begin
			gap = $urandom_range(0, 15);
			m_tready <= (gap == 0);
			rx_wait <= gap;
		end else if (!m_tready) begin
			if (rx_wait <= 1) m_tready <= 1;
			if (rx_wait > 0) rx_wait <= rx_wait - 1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_word(logic [9*DW-1:0] w, bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= IN_W'(w);
		do @(posedge clk); while (!s_tready);
	endtask

	function automatic logic [DW-1:0] pick_entry();
		case ($urandom_range(0, 5))
			0: return DW'(ONE);
			1: return DW'(-ONE);
			2: return '0;
			3: return {1'b0, {(DW-1){1'b1}}};
			4: return {1'b1, {(DW-1){1'b0}}};
			default: return DW'($urandom_range(0, ONE * 2) - ONE);
		endcase
	endfunction

	// Near-rotation matrices from a random quaternion, plus some raw noise.
	function automatic logic [9*DW-1:0] random_matrix();
		logic [9*DW-1:0] w;
		real a, b, c, d, n, r[9];
		if ($urandom_range(0, 4) == 0) begin
			for (int i = 0; i < 9; i++)
				w[i*DW +: DW] = ($urandom_range(0, 1)) ? pick_entry() : DW'($urandom);
			return w;
		end
		a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
		c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(0, 2000) - 1000.0;
		n = a*a + b*b + c*c + d*d + 1.0;
		r = '{1 - 2*(c*c + d*d)/n, 2*(b*c - a*d)/n, 2*(b*d + a*c)/n,
		      2*(b*c + a*d)/n, 1 - 2*(b*b + d*d)/n, 2*(c*d - a*b)/n,
		      2*(b*d - a*c)/n, 2*(c*d + a*b)/n, 1 - 2*(b*b + c*c)/n};
		for (int i = 0; i < 9; i++)
			w[i*DW +: DW] = DW'($rtoi(r[i] * ONE) + $signed($urandom_range(0, 4)) - 2);
		return w;
	endfunction

	task automatic write_eps(logic [DW-1:0] v);
		s_tvalid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		logic [9*DW-1:0] w;
		logic [DW-1:0] eps_set[4];
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// Identity, the half-turns, zero matrix and the field extremes.
		send_word({DW'(ONE), 16'd0, 16'd0, 16'd0, DW'(ONE), 16'd0, 16'd0, 16'd0, DW'(ONE)}, 0);
		send_word({DW'(ONE), 16'd0, 16'd0, 16'd0, DW'(-ONE), 16'd0, 16'd0, 16'd0, DW'(-ONE)}, 0);
		send_word({DW'(-ONE), 16'd0, 16'd0, 16'd0, DW'(ONE), 16'd0, 16'd0, 16'd0, DW'(-ONE)}, 0);
		send_word({DW'(-ONE), 16'd0, 16'd0, 16'd0, DW'(-ONE), 16'd0, 16'd0, 16'd0, DW'(ONE)}, 0);
		send_word('0, 0);
		send_word({9{16'h7fff}}, 0);
		send_word({9{16'h8000}}, 0);
		send_word({9{16'hffff}}, 0);
		send_word({9{16'h5555}}, 0);
		send_word({9{16'haaaa}}, 0);
		// Trace term not positive, in two different case groups.
		send_word({DW'(ONE), 16'd0, 16'd0, 16'd0, DW'(ONE), 16'd0, 16'd0, 16'd0, DW'(-ONE*2)}, 0);
		send_word({DW'(-ONE), 16'd0, 16'd0, 16'd0, DW'(-ONE), 16'd0, 16'd0, 16'd0, DW'(-ONE)}, 0);
		for (int i = 0; i < 8; i++) send_word(random_matrix(), 0);
		eps_set = '{16'h8000, 16'h7fff, DW'(-ONE / 2), 16'h0000};
		for (int ph = 0; ph < 4; ph++) begin
			write_eps(eps_set[ph]);
			for (int i = 0; i < 235; i++) begin
				if (ph == 1 && i == 20) begin
					hold_off <= 1;
					fork
						begin repeat (1500) @(posedge clk); hold_off <= 0; end
					join_none
				end
				w = random_matrix();
				send_word(w, $urandom_range(0, 3) == 0);
			end
		end
		s_tvalid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
